[sv/elevator_direction_controller_macros.svh]
// ---------------------------------------------------------------------------
// elevator direction controller assertion macros
// concurrent assertion wrappers, empty when synthesized
// ---------------------------------------------------------------------------
`ifndef ELEVATOR_DIRECTION_CONTROLLER_MACROS_SVH
`define ELEVATOR_DIRECTION_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock out of reset
`define EDC_ASSERT(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("edc assertion failed");

// consequence must hold in the cycle after the trigger
`define EDC_ASSERT_NEXT(label, trig, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (expr)) \
      else $error("edc assertion failed");

`else

`define EDC_ASSERT(label, expr)
`define EDC_ASSERT_NEXT(label, trig, expr)

`endif

`endif

[sv/edc_pkg.sv]
// ---------------------------------------------------------------------------
// edc_pkg
// shared types, codes and helper functions of the elevator controller
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package edc_pkg;

   // number of floors kept in the request masks
   localparam int NUM_FLOORS = 16;
   localparam int FLOOR_W    = 4;
   localparam int MAX_TOP    = (NUM_FLOORS - 1 > 15) ? 15 : NUM_FLOORS - 1;

   typedef logic [NUM_FLOORS-1:0] mask_type;
   typedef logic [FLOOR_W-1:0]    floor_type;
   typedef logic [1:0]            dir_type;
   typedef logic [1:0]            req_kind_type;

   // travel direction and hall call direction codes
   localparam dir_type DIR_IDLE = 2'b00;
   localparam dir_type DIR_UP   = 2'b01;
   localparam dir_type DIR_DOWN = 2'b11;

   // request kind codes on the input channel
   localparam req_kind_type REQ_TICK = 2'd0;
   localparam req_kind_type REQ_HALL = 2'd1;
   localparam req_kind_type REQ_CAR  = 2'd2;

   localparam floor_type TOP_FLOOR_RESET = 4'd15;

   // classified command passed from front to back
   typedef enum logic [2:0] {
      CMD_NOP,
      CMD_TICK,
      CMD_HALL_UP,
      CMD_HALL_DOWN,
      CMD_CAR
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      floor_type    floor;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   // highest floor actually served
   function automatic floor_type eff_top(input floor_type top);
      if (top > floor_type'(MAX_TOP)) begin
         return floor_type'(MAX_TOP);
      end
      return top;
   endfunction

   // bits 0 .. n-1 set
   function automatic mask_type low_mask(input logic [FLOOR_W:0] n);
      mask_type m;
      for (int i = 0; i < NUM_FLOORS; i++) begin
         m[i] = (i < int'(n));
      end
      return m;
   endfunction

   // priority chain for the next direction
   function automatic dir_type choose_dir(input dir_type dir, input logic above,
                                          input logic below);
      if (dir == DIR_UP && above) begin
         return DIR_UP;
      end else if (dir == DIR_UP && below) begin
         return DIR_DOWN;
      end else if (dir == DIR_DOWN && below) begin
         return DIR_DOWN;
      end else if (dir == DIR_DOWN && above) begin
         return DIR_UP;
      end else if (!above && !below) begin
         return DIR_IDLE;
      end else if (dir == DIR_IDLE && above) begin
         return DIR_UP;
      end else if (dir == DIR_IDLE && below) begin
         return DIR_DOWN;
      end
      return dir;
   endfunction

endpackage

[sv/elevator_direction_controller.sv]
// flow: an accepted request is queued, then popped by the back end into the response register
// throughput: one request per cycle while rsp_tready holds, sustained through the two-entry
//   command queue and the response register; the back end takes one command per cycle
// reset: synchronous; clears request masks, car at floor 0, idle, door closed,
//   top floor 15 and an empty queue
// ---------------------------------------------------------------------------
// elevator_direction_controller
// single-car collective control elevator, decoupled front and back
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "elevator_direction_controller_macros.svh"

module elevator_direction_controller (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [3:0] csr_wr_data,   // top_floor
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,     // floor[3:0], hall_dir[5:4], zero[7:6]
   input  logic [1:0] req_tuser,     // req_type[1:0]
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata      // cur_floor[3:0], direction[5:4], door_open[6], zero[7]
);

   edc_pkg::floor_type       top_floor_ff, top_floor_in;
   edc_pkg::fifo_status_type fifo_status;
   edc_pkg::cmd_type         push_cmd;
   edc_pkg::cmd_type         head_cmd;
   logic                     push;
   logic                     pop;
   edc_pkg::floor_type       rsp_floor;
   edc_pkg::dir_type         rsp_dir;
   logic                     rsp_door;

   // top floor register
   assign top_floor_in = csr_wr_en ? csr_wr_data : top_floor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         top_floor_ff <= edc_pkg::TOP_FLOOR_RESET;
      end else begin
         top_floor_ff <= top_floor_in;
      end
   end

   edc_front u_front (
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_kind     (req_tuser),
      .req_floor    (req_tdata[3:0]),
      .req_hall_dir (req_tdata[5:4]),
      .top_floor    (top_floor_ff),
      .fifo_status  (fifo_status),
      .push         (push),
      .cmd          (push_cmd)
   );

   edc_cmd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (fifo_status)
   );

   edc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (!fifo_status.empty),
      .cmd        (head_cmd),
      .pop        (pop),
      .top_floor  (top_floor_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_floor  (rsp_floor),
      .rsp_dir    (rsp_dir),
      .rsp_door   (rsp_door)
   );

   assign rsp_tdata = {1'b0, rsp_door, rsp_dir, rsp_floor};

   // checks
   `EDC_ASSERT(a_door_open_idle, !(rsp_tvalid && rsp_door) || rsp_dir == edc_pkg::DIR_IDLE)
   `EDC_ASSERT(a_no_pop_empty, !(pop && fifo_status.empty))
   `EDC_ASSERT(a_no_push_full, !(push && fifo_status.full))
   `EDC_ASSERT_NEXT(a_push_lands, push && !pop, !fifo_status.empty)

endmodule

[sv/edc_front.sv]
// ---------------------------------------------------------------------------
// edc_front
// accepts requests and classifies them into commands for the queue
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module edc_front (
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  edc_pkg::req_kind_type    req_kind,
   input  edc_pkg::floor_type       req_floor,
   input  edc_pkg::dir_type         req_hall_dir,
   input  edc_pkg::floor_type       top_floor,
   input  edc_pkg::fifo_status_type fifo_status,
   output logic                     push,
   output edc_pkg::cmd_type         cmd
);

   logic valid_floor;

   // handshake into the queue
   assign req_tready = !fifo_status.full;
   assign push       = req_tvalid && req_tready;

   assign valid_floor = (req_floor <= edc_pkg::eff_top(top_floor));

   // classify the request
   always_comb begin
      cmd.floor = req_floor;
      unique case (req_kind)
         edc_pkg::REQ_TICK: begin
            cmd.kind = edc_pkg::CMD_TICK;
         end
         edc_pkg::REQ_HALL: begin
            if (valid_floor && req_hall_dir == edc_pkg::DIR_UP) begin
               cmd.kind = edc_pkg::CMD_HALL_UP;
            end else if (valid_floor && req_hall_dir == edc_pkg::DIR_DOWN) begin
               cmd.kind = edc_pkg::CMD_HALL_DOWN;
            end else begin
               cmd.kind = edc_pkg::CMD_NOP;
            end
         end
         edc_pkg::REQ_CAR: begin
            cmd.kind = valid_floor ? edc_pkg::CMD_CAR : edc_pkg::CMD_NOP;
         end
         default: begin
            cmd.kind = edc_pkg::CMD_NOP;
         end
      endcase
   end

endmodule

[sv/edc_cmd_fifo.sv]
// ---------------------------------------------------------------------------
// edc_cmd_fifo
// two-entry command queue between front and back
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module edc_cmd_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  edc_pkg::cmd_type         push_cmd,
   input  logic                     pop,
   output edc_pkg::cmd_type         head_cmd,
   output edc_pkg::fifo_status_type status
);

   edc_pkg::cmd_type entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);
   assign head_cmd     = entry_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[sv/edc_back.sv]
// ---------------------------------------------------------------------------
// edc_back
// carries out commands on the request masks and car state, drives responses
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module edc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   input  edc_pkg::cmd_type      cmd,
   output logic                  pop,
   input  edc_pkg::floor_type    top_floor,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output edc_pkg::floor_type    rsp_floor,
   output edc_pkg::dir_type      rsp_dir,
   output logic                  rsp_door
);

   edc_pkg::mask_type  hall_up_ff, hall_up_in;
   edc_pkg::mask_type  hall_down_ff, hall_down_in;
   edc_pkg::mask_type  car_call_ff, car_call_in;
   edc_pkg::floor_type car_floor_ff, car_floor_in;
   edc_pkg::dir_type   travel_dir_ff, travel_dir_in;
   logic               door_ff, door_in;
   logic               rsp_valid_ff, rsp_valid_in;
   edc_pkg::floor_type rsp_floor_ff;
   edc_pkg::dir_type   rsp_dir_ff;
   logic               rsp_door_ff;

   edc_pkg::mask_type  all_req;
   edc_pkg::mask_type  top_win;
   edc_pkg::mask_type  call_bit;
   edc_pkg::mask_type  here;
   edc_pkg::floor_type moved_floor;
   edc_pkg::dir_type   first_dir;
   edc_pkg::dir_type   second_dir;
   logic               above1, below1, above2, below2;

   // take a command when the output register is free or draining
   assign pop = cmd_valid && (!rsp_valid_ff || rsp_tready);

   // tick: find requests, choose direction, move, choose again
   always_comb begin
      all_req  = hall_up_ff | hall_down_ff | car_call_ff;
      top_win  = edc_pkg::low_mask({1'b0, edc_pkg::eff_top(top_floor)} + 5'd1);
      call_bit = edc_pkg::mask_type'(1) << cmd.floor;

      above1 = |(all_req & top_win & ~edc_pkg::low_mask({1'b0, car_floor_ff} + 5'd1));
      below1 = |(all_req & edc_pkg::low_mask({1'b0, car_floor_ff}));
      first_dir = edc_pkg::choose_dir(travel_dir_ff, above1, below1);

      if (first_dir == edc_pkg::DIR_UP && above1) begin
         moved_floor = car_floor_ff + 4'd1;
      end else if (first_dir == edc_pkg::DIR_DOWN && below1) begin
         moved_floor = car_floor_ff - 4'd1;
      end else begin
         moved_floor = car_floor_ff;
      end

      here   = edc_pkg::mask_type'(1) << moved_floor;
      above2 = |(all_req & top_win & ~edc_pkg::low_mask({1'b0, moved_floor} + 5'd1))
               || |(hall_up_ff & here);
      below2 = |(all_req & edc_pkg::low_mask({1'b0, moved_floor}))
               || |(hall_down_ff & here);
      second_dir = edc_pkg::choose_dir(first_dir, above2, below2);
   end

   // next state per command kind
   always_comb begin
      hall_up_in    = hall_up_ff;
      hall_down_in  = hall_down_ff;
      car_call_in   = car_call_ff;
      car_floor_in  = car_floor_ff;
      travel_dir_in = travel_dir_ff;
      door_in       = door_ff;
      if (pop) begin
         unique case (cmd.kind)
            edc_pkg::CMD_TICK: begin
               car_floor_in  = moved_floor;
               travel_dir_in = second_dir;
               door_in       = 1'b0;
               // stop and clear a matching request at the new floor
               if (|(car_call_ff & here) && travel_dir_in != edc_pkg::DIR_IDLE) begin
                  travel_dir_in = edc_pkg::DIR_IDLE;
                  door_in       = 1'b1;
                  car_call_in   = car_call_ff & ~here;
               end
               if (|(hall_up_ff & here) && travel_dir_in == edc_pkg::DIR_UP) begin
                  travel_dir_in = edc_pkg::DIR_IDLE;
                  door_in       = 1'b1;
                  hall_up_in    = hall_up_ff & ~here;
               end
               if (|(hall_down_ff & here) && travel_dir_in == edc_pkg::DIR_DOWN) begin
                  travel_dir_in = edc_pkg::DIR_IDLE;
                  door_in       = 1'b1;
                  hall_down_in  = hall_down_ff & ~here;
               end
            end
            edc_pkg::CMD_HALL_UP: begin
               hall_up_in = hall_up_ff | call_bit;
            end
            edc_pkg::CMD_HALL_DOWN: begin
               hall_down_in = hall_down_ff | call_bit;
            end
            edc_pkg::CMD_CAR: begin
               car_call_in = car_call_ff | call_bit;
            end
            default: begin
            end
         endcase
      end
   end

   // output register valid
   always_comb begin
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hall_up_ff    <= '0;
         hall_down_ff  <= '0;
         car_call_ff   <= '0;
         car_floor_ff  <= '0;
         travel_dir_ff <= edc_pkg::DIR_IDLE;
         door_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hall_up_ff    <= hall_up_in;
         hall_down_ff  <= hall_down_in;
         car_call_ff   <= car_call_in;
         car_floor_ff  <= car_floor_in;
         travel_dir_ff <= travel_dir_in;
         door_ff       <= door_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_floor_ff <= car_floor_in;
         rsp_dir_ff   <= travel_dir_in;
         rsp_door_ff  <= door_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_floor  = rsp_floor_ff;
   assign rsp_dir    = rsp_dir_ff;
   assign rsp_door   = rsp_door_ff;

endmodule

[dv/elevator_direction_controller_test.sv]
// ---------------------------------------------------------------------------
// elevator_direction_controller_test
// self-checking bench: hall calls, car calls and move ticks go in on the
// request stream, a scoreboard predicts car floor, direction and door state
// for every request and checks each response in order, across several
// top-floor settings and idle patterns on both sides
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module elevator_direction_controller_test;

   // request kind with no meaning, and a hall direction that is ignored
   localparam edc_pkg::req_kind_type REQ_UNUSED   = 2'd3;
   localparam edc_pkg::dir_type      HALL_DIR_BAD = 2'b10;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_PER_PHASE = 140;

   // packed like rsp_tdata bits 6:0
   typedef struct packed {
      logic               door;
      edc_pkg::dir_type   heading;
      edc_pkg::floor_type floor;
   } car_status_type;

   // ------------------------------------------------------------------
   // scoreboard: own copy of the call masks and car state
   // ------------------------------------------------------------------
   class car_status_board;
      edc_pkg::mask_type  up_calls;
      edc_pkg::mask_type  down_calls;
      edc_pkg::mask_type  cabin_calls;
      edc_pkg::floor_type car_at;
      edc_pkg::floor_type top;
      edc_pkg::dir_type   heading;
      logic               door;
      car_status_type     expected_status[$];
      int                 errors;

      function new();
         up_calls    = '0;
         down_calls  = '0;
         cabin_calls = '0;
         car_at      = '0;
         top         = edc_pkg::TOP_FLOOR_RESET;
         heading     = edc_pkg::DIR_IDLE;
         door        = 1'b0;
         errors      = 0;
      endfunction

      function int pending();
         return expected_status.size();
      endfunction

      // floors strictly under n
      function edc_pkg::mask_type floors_under(int n);
         edc_pkg::mask_type m;
         m = '0;
         for (int i = 0; i < edc_pkg::NUM_FLOORS; i++) begin
            if (i < n) begin
               m[i] = 1'b1;
            end
         end
         return m;
      endfunction

      // any call above the car (up to the top floor) or below it
      function void scan_calls(output logic above, output logic below);
         edc_pkg::mask_type all_calls;
         edc_pkg::mask_type upper;
         all_calls = up_calls | down_calls | cabin_calls;
         upper = floors_under(int'(top) + 1) & ~floors_under(int'(car_at) + 1);
         above = |(all_calls & upper);
         below = |(all_calls & floors_under(int'(car_at)));
      endfunction

      // keep heading while calls lie ahead, else turn, else stop
      function edc_pkg::dir_type pick_heading(edc_pkg::dir_type cur, logic above,
                                              logic below);
         case (cur)
            edc_pkg::DIR_UP: begin
               return above ? edc_pkg::DIR_UP :
                      (below ? edc_pkg::DIR_DOWN : edc_pkg::DIR_IDLE);
            end
            edc_pkg::DIR_DOWN: begin
               return below ? edc_pkg::DIR_DOWN :
                      (above ? edc_pkg::DIR_UP : edc_pkg::DIR_IDLE);
            end
            default: begin
               return above ? edc_pkg::DIR_UP :
                      (below ? edc_pkg::DIR_DOWN : edc_pkg::DIR_IDLE);
            end
         endcase
      endfunction

      // one move tick: close door, step a floor, serve calls at the new floor
      function void move_car();
         logic              above;
         logic              below;
         edc_pkg::mask_type here;
         door = 1'b0;
         scan_calls(above, below);
         heading = pick_heading(heading, above, below);
         if (heading == edc_pkg::DIR_UP && above) begin
            car_at = car_at + 4'd1;
         end else if (heading == edc_pkg::DIR_DOWN && below) begin
            car_at = car_at - 4'd1;
         end
         scan_calls(above, below);
         here = edc_pkg::mask_type'(1) << car_at;
         // hall calls at this floor steer the second choice
         if (|(up_calls & here)) begin
            above = 1'b1;
         end
         if (|(down_calls & here)) begin
            below = 1'b1;
         end
         heading = pick_heading(heading, above, below);
         if (|(cabin_calls & here) && heading != edc_pkg::DIR_IDLE) begin
            heading     = edc_pkg::DIR_IDLE;
            door        = 1'b1;
            cabin_calls = cabin_calls & ~here;
         end
         if (|(up_calls & here) && heading == edc_pkg::DIR_UP) begin
            heading  = edc_pkg::DIR_IDLE;
            door     = 1'b1;
            up_calls = up_calls & ~here;
         end
         if (|(down_calls & here) && heading == edc_pkg::DIR_DOWN) begin
            heading    = edc_pkg::DIR_IDLE;
            door       = 1'b1;
            down_calls = down_calls & ~here;
         end
      endfunction

      // accepted request: update state and queue the expected status
      function void note_request(edc_pkg::req_kind_type kind, edc_pkg::floor_type fl,
                                 edc_pkg::dir_type hd);
         logic              served;
         edc_pkg::mask_type bit_at;
         car_status_type    status;
         served = int'(fl) <= int'(top);
         bit_at = edc_pkg::mask_type'(1) << fl;
         case (kind)
            edc_pkg::REQ_TICK: begin
               move_car();
            end
            edc_pkg::REQ_HALL: begin
               if (served && hd == edc_pkg::DIR_UP) begin
                  up_calls = up_calls | bit_at;
               end else if (served && hd == edc_pkg::DIR_DOWN) begin
                  down_calls = down_calls | bit_at;
               end
            end
            edc_pkg::REQ_CAR: begin
               if (served) begin
                  cabin_calls = cabin_calls | bit_at;
               end
            end
            default: begin
            end
         endcase
         status.door    = door;
         status.heading = heading;
         status.floor   = car_at;
         expected_status.push_back(status);
      endfunction

      task report_mismatch(string what);
         errors++;
         $display("%0t ns mismatch: %s", $time, what);
      endtask

      // accepted response against the oldest expected status
      task check_response(logic [7:0] data);
         car_status_type got;
         car_status_type want;
         got = car_status_type'(data[6:0]);
         if (expected_status.size() == 0) begin
            report_mismatch($sformatf("response %h with nothing expected", data));
            return;
         end
         want = expected_status.pop_front();
         if (got.floor !== want.floor) begin
            report_mismatch($sformatf("cur_floor %0d, expected %0d", got.floor, want.floor));
         end
         if (got.heading !== want.heading) begin
            report_mismatch($sformatf("direction %b, expected %b",
                                      got.heading, want.heading));
         end
         if (got.door !== want.door) begin
            report_mismatch($sformatf("door_open %b, expected %b", got.door, want.door));
         end
      endtask
   endclass

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       csr_wr_en   = 1'b0;
   logic [3:0] csr_wr_data = 4'd0;
   logic       req_tvalid  = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata   = 8'd0;   // floor[3:0], hall_dir[5:4], zero[7:6]
   logic [1:0] req_tuser   = 2'd0;   // req_type[1:0]
   logic       rsp_tvalid;
   logic       rsp_tready  = 1'b0;
   logic [7:0] rsp_tdata;            // cur_floor[3:0], direction[5:4], door_open[6], zero[7]

   car_status_board board = new();
   int send_gap_pct   = 0;
   int recv_stall_pct = 0;
   int idle_cycles    = 0;

   elevator_direction_controller dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   always #6 clock = ~clock;

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // handshake monitor: responses first, they belong to older requests
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            board.check_response(rsp_tdata);
         end
         if (req_tvalid && req_tready) begin
            board.note_request(req_tuser, req_tdata[3:0], req_tdata[5:4]);
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("elevator_direction_controller_test: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // one request, with a random gap first; returns just after acceptance
   task automatic send_request(input edc_pkg::req_kind_type kind,
                               input edc_pkg::floor_type fl,
                               input edc_pkg::dir_type hd);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, hd, fl};
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
   endtask

   // stop sending, wait for every response, then pick the next idle pattern
   task automatic settle_block(input int gap_pct, input int stall_pct);
      req_tvalid <= 1'b0;
      do @(negedge clock); while (board.pending() != 0);
      send_gap_pct   = gap_pct;
      recv_stall_pct = stall_pct;
      repeat (3) @(posedge clock);
   endtask

   task automatic write_top_floor(input edc_pkg::floor_type value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      board.top = value;
   endtask

   // mostly sensible calls and ticks, a little noise
   task automatic send_random_request();
      int                    pick;
      edc_pkg::req_kind_type kind;
      edc_pkg::floor_type    fl;
      edc_pkg::dir_type      hd;
      pick = $urandom_range(99);
      if ($urandom_range(99) < 85) begin
         fl = edc_pkg::floor_type'($urandom_range(board.top));
      end else begin
         fl = edc_pkg::floor_type'($urandom_range(15));
      end
      if ($urandom_range(9) < 9) begin
         hd = $urandom_range(1) ? edc_pkg::DIR_UP : edc_pkg::DIR_DOWN;
      end else begin
         hd = edc_pkg::dir_type'($urandom_range(3));
      end
      if (pick < 45) begin
         kind = edc_pkg::REQ_TICK;
      end else if (pick < 72) begin
         kind = edc_pkg::REQ_HALL;
      end else if (pick < 95) begin
         kind = edc_pkg::REQ_CAR;
      end else begin
         kind = REQ_UNUSED;
      end
      send_request(kind, fl, hd);
   endtask

   int                 gap_table[4]   = '{0, 87, 0, 35};
   int                 stall_table[4] = '{0, 0, 87, 35};
   edc_pkg::floor_type phase_tops[8]  = '{4'd15, 4'd9, 4'd0, 4'd4, 4'd15, 4'd2, 4'd12, 4'd7};

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: unused kind, idle car call, ignored hall calls, a trip up
      write_top_floor(4'd15);
      send_request(REQ_UNUSED, 4'd15, edc_pkg::DIR_DOWN);
      send_request(edc_pkg::REQ_TICK, 4'd0, edc_pkg::DIR_IDLE);
      send_request(edc_pkg::REQ_CAR, 4'd0, edc_pkg::DIR_IDLE);
      send_request(edc_pkg::REQ_TICK, 4'd0, edc_pkg::DIR_IDLE);
      send_request(edc_pkg::REQ_HALL, 4'd8, edc_pkg::DIR_IDLE);
      send_request(edc_pkg::REQ_HALL, 4'd9, HALL_DIR_BAD);
      send_request(edc_pkg::REQ_HALL, 4'd2, edc_pkg::DIR_UP);
      send_request(edc_pkg::REQ_HALL, 4'd0, edc_pkg::DIR_DOWN);
      send_request(edc_pkg::REQ_CAR, 4'd15, edc_pkg::DIR_UP);
      repeat (6) send_request(edc_pkg::REQ_TICK, 4'd15, edc_pkg::DIR_DOWN);

      // directed: calls above a lowered top floor, car left above it
      settle_block(0, 0);
      write_top_floor(4'd3);
      send_request(edc_pkg::REQ_CAR, 4'd12, edc_pkg::DIR_IDLE);
      send_request(edc_pkg::REQ_HALL, 4'd3, edc_pkg::DIR_UP);
      send_request(edc_pkg::REQ_CAR, 4'd3, edc_pkg::DIR_IDLE);
      repeat (4) send_request(edc_pkg::REQ_TICK, 4'd0, edc_pkg::DIR_IDLE);

      // random phases over top-floor settings and idle patterns
      phase_tops[7] = edc_pkg::floor_type'($urandom_range(15));
      for (int p = 0; p < 8; p++) begin
         settle_block(gap_table[p % 4], stall_table[p % 4]);
         write_top_floor(phase_tops[p]);
         repeat (RANDOM_PER_PHASE) send_random_request();
      end

      // drain and look for stray responses
      settle_block(0, 0);
      repeat (4) @(posedge clock);
      @(negedge clock);
      if (board.errors == 0) begin
         $display("elevator_direction_controller_test: clean");
      end else begin
         $display("elevator_direction_controller_test: errors");
      end
      $finish;
   end

endmodule
